>>> rtl/best_fit_heap_allocator_assert.svh
// Assertion macros for the best-fit heap allocator.
// Expects signals named clk and arst_n in the scope of use.
`ifndef BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFHA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bfha: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BFHA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bfha: next-cycle check failed");

`endif

>>> rtl/bfha_pkg.sv
// Shared constants for the best-fit heap allocator.
// No dependencies.
`default_nettype none
package bfha_pkg;
	localparam int HEAP_BYTES_DEF   = 1048576;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int ALIGN_BYTES_DEF  = 16;
	localparam int MAX_SEGMENTS_DEF = 64;

	localparam int REQ_W  = 21;
	localparam int ADDR_W = 32;
	// Request plus header plus alignment padding always fits in this width.
	localparam int NEED_W = 22;

	localparam logic [1:0] ST_ALLOC   = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_FREED   = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;
endpackage
`default_nettype wire

>>> rtl/bfha_ram.sv
// Generic simple dual-port RAM with a registered read.
// No dependencies.
`default_nettype none
module bfha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/bfha_round.sv
// Alignment unit: rounds a byte count up to a multiple of ALIGN_BYTES, with a registered result.
// Depends on bfha_pkg.
`default_nettype none
module bfha_round #(
	parameter int ALIGN_BYTES = bfha_pkg::ALIGN_BYTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [bfha_pkg::NEED_W-1:0] raw,
	output logic                             done,
	output logic      [bfha_pkg::NEED_W-1:0] need
);
	// The alignment is a power of two, so rounding up is an add and a mask.
	localparam logic [bfha_pkg::NEED_W-1:0] MASK = bfha_pkg::NEED_W'(ALIGN_BYTES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			need <= '0;
		end else begin
			done <= go;
			if (go) begin
				need <= (raw + MASK) & ~MASK;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/best_fit_heap_allocator.sv
// Best-fit heap allocator: top level with the request sequencer and segment table.
// Depends on bfha_pkg, bfha_ram, bfha_round and best_fit_heap_allocator_assert.svh.
`default_nettype none
// A request is taken when start is high and busy is low; exactly one result follows,
// shown for a single cycle with done high, and the receiver cannot hold it off, so it
// must take every result as it appears. The segment table lives in one RAM with a
// registered read, and every request walks it through that single read port. An
// allocate transaction rounds the size for alignment, then scans every table entry
// for the best fit, decides, and on a split moves each later entry up by one, then
// makes one or two writes. A free transaction scans until the address matches, reads
// the next neighbour, writes the merged segment and then moves each later entry down.
// The length of a request is set by the segment count and the number of entries that
// move. There is no clearing pass after reset: entry 0 is covered by a flag until
// first written, and entries beyond the segment count are never used.
// heap_start may only be written while busy is low.
module best_fit_heap_allocator #(
	parameter int HEAP_BYTES   = bfha_pkg::HEAP_BYTES_DEF,
	parameter int HEADER_BYTES = bfha_pkg::HEADER_BYTES_DEF,
	parameter int ALIGN_BYTES  = bfha_pkg::ALIGN_BYTES_DEF,
	parameter int MAX_SEGMENTS = bfha_pkg::MAX_SEGMENTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        kind,
	input  wire logic [bfha_pkg::REQ_W-1:0]  request_bytes,
	input  wire logic [bfha_pkg::ADDR_W-1:0] free_address,
	input  wire logic                        cfg_wen,
	input  wire logic [bfha_pkg::ADDR_W-1:0] cfg_wdata,
	output logic                             done,
	output logic      [1:0]                  status,
	output logic      [bfha_pkg::ADDR_W-1:0] address
);
	localparam int LEN_W = $clog2(HEAP_BYTES + 1);
	localparam int ENT_W = 2 * LEN_W + 1;
	localparam int IDX_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int CMP_W = (LEN_W > bfha_pkg::NEED_W) ? LEN_W : bfha_pkg::NEED_W;
	localparam int AW    = bfha_pkg::ADDR_W;

	typedef enum logic [3:0] {
		S_IDLE, S_ROUND, S_SCAN, S_ADEC, S_A_SPLIT, S_A_BEST,
		S_FNXT_RD, S_FNXT_WT, S_FMERGE, S_FFIN, S_SH_RD, S_SH_WR
	} state_t;

	// An entry is {in use, length, offset}.
	localparam logic [ENT_W-1:0] RESET_ENT = {1'b0, LEN_W'(HEAP_BYTES), LEN_W'(0)};

	state_t                      state_q;
	logic [CNT_W-1:0]            count_q;
	logic                        ent0_v_q;
	logic [AW-1:0]               heap_start_q;
	logic                        kind_q;
	logic [AW-1:0]               want_q;
	logic [bfha_pkg::NEED_W-1:0] need_q;
	logic [CNT_W-1:0]            scan_q;
	logic                        v_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [IDX_W-1:0]            rd_addr_s1;
	logic                        found_q;
	logic [IDX_W-1:0]            best_q;
	logic [CMP_W-1:0]            best_diff_q;
	logic [LEN_W-1:0]            best_off_q;
	logic [LEN_W-1:0]            best_len_q;
	logic                        split_q;
	logic [ENT_W-1:0]            prev_q;
	logic [ENT_W-1:0]            match_q;
	logic [ENT_W-1:0]            next_q;
	logic                        pf_q;
	logic                        nf_q;
	logic [1:0]                  gone_q;
	logic [CNT_W-1:0]            sh_src_q;
	logic [CNT_W-1:0]            sh_cnt_q;
	logic                        sh_up_q;

	logic                        ram_we;
	logic [IDX_W-1:0]            ram_waddr;
	logic [ENT_W-1:0]            ram_wdata;
	logic [IDX_W-1:0]            ram_raddr;
	logic [ENT_W-1:0]            ram_rdata;
	logic [ENT_W-1:0]            ent_rd;

	logic                        accept;
	logic                        round_go;
	logic                        round_done;
	logic [bfha_pkg::NEED_W-1:0] round_need;

	logic                        rd_use;
	logic [LEN_W-1:0]            rd_len;
	logic [LEN_W-1:0]            rd_off;
	logic [CMP_W-1:0]            rd_diff;
	logic                        rd_better;
	logic                        rd_match;
	logic                        scan_issue;
	logic [CNT_W-1:0]            best_nxt;
	logic [CNT_W-1:0]            lo_idx;
	logic [CNT_W-1:0]            hi_idx;
	logic [LEN_W-1:0]            merged_len;
	logic [LEN_W-1:0]            merged_off;
	logic [CNT_W-1:0]            sh_dst;
	logic                        do_split;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign round_go = accept && (kind == bfha_pkg::KIND_ALLOC);

	bfha_round #(
		.ALIGN_BYTES (ALIGN_BYTES)
	) u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (round_go),
		.raw    (bfha_pkg::NEED_W'(request_bytes) + bfha_pkg::NEED_W'(HEADER_BYTES)),
		.done   (round_done),
		.need   (round_need)
	);

	bfha_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_SEGMENTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Entry 0 reads as the whole free heap until it has been written once.
	assign ent_rd = (rd_addr_s1 == '0 && !ent0_v_q) ? RESET_ENT : ram_rdata;

	always_comb begin
		rd_use     = ent_rd[ENT_W-1];
		rd_len     = ent_rd[2*LEN_W-1:LEN_W];
		rd_off     = ent_rd[LEN_W-1:0];
		rd_diff    = CMP_W'(rd_len) - CMP_W'(need_q);
		rd_better  = !rd_use && (CMP_W'(rd_len) >= CMP_W'(need_q))
			&& (!found_q || rd_diff < best_diff_q);
		rd_match   = (AW'(rd_off) == want_q);
		scan_issue = (scan_q < count_q);
		best_nxt   = CNT_W'(best_q) + 1'b1;
		lo_idx     = CNT_W'(best_q) - CNT_W'(pf_q);
		hi_idx     = CNT_W'(best_q) + CNT_W'(nf_q);
		merged_off = pf_q ? prev_q[LEN_W-1:0] : match_q[LEN_W-1:0];
		merged_len = match_q[2*LEN_W-1:LEN_W]
			+ (pf_q ? prev_q[2*LEN_W-1:LEN_W] : LEN_W'(0))
			+ (nf_q ? next_q[2*LEN_W-1:LEN_W] : LEN_W'(0));
		sh_dst     = sh_up_q ? sh_src_q - CNT_W'(gone_q) : sh_src_q + 1'b1;
		do_split   = (best_diff_q > CMP_W'(2 * HEADER_BYTES))
			&& (count_q < CNT_W'(MAX_SEGMENTS));
	end

	// Table port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = scan_q[IDX_W-1:0];
		unique case (state_q)
			S_FNXT_RD: begin
				ram_raddr = best_nxt[IDX_W-1:0];
			end
			S_SH_RD: begin
				ram_raddr = sh_src_q[IDX_W-1:0];
			end
			S_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = sh_dst[IDX_W-1:0];
				ram_wdata = ent_rd;
			end
			S_FMERGE: begin
				ram_we    = 1'b1;
				ram_waddr = lo_idx[IDX_W-1:0];
				ram_wdata = {1'b0, merged_len, merged_off};
			end
			S_A_SPLIT: begin
				ram_we    = 1'b1;
				ram_waddr = best_nxt[IDX_W-1:0];
				ram_wdata = {1'b0, best_diff_q[LEN_W-1:0],
					best_off_q + LEN_W'(need_q)};
			end
			S_A_BEST: begin
				ram_we    = 1'b1;
				ram_waddr = best_q;
				ram_wdata = {1'b1, split_q ? LEN_W'(need_q) : best_len_q, best_off_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequencer: state, table bookkeeping and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= CNT_W'(1);
			ent0_v_q     <= 1'b0;
			heap_start_q <= '0;
			kind_q       <= bfha_pkg::KIND_ALLOC;
			want_q       <= '0;
			need_q       <= '0;
			scan_q       <= '0;
			v_s1         <= 1'b0;
			idx_s1       <= '0;
			rd_addr_s1   <= '0;
			found_q      <= 1'b0;
			best_q       <= '0;
			best_diff_q  <= '0;
			best_off_q   <= '0;
			best_len_q   <= '0;
			split_q      <= 1'b0;
			prev_q       <= '0;
			match_q      <= '0;
			next_q       <= '0;
			pf_q         <= 1'b0;
			nf_q         <= 1'b0;
			gone_q       <= '0;
			sh_src_q     <= '0;
			sh_cnt_q     <= '0;
			sh_up_q      <= 1'b0;
			done         <= 1'b0;
			status       <= bfha_pkg::ST_ALLOC;
			address      <= '0;
		end else begin
			done       <= 1'b0;
			rd_addr_s1 <= ram_raddr;
			if (cfg_wen) begin
				heap_start_q <= cfg_wdata;
			end
			if (ram_we && ram_waddr == '0) begin
				ent0_v_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q  <= kind;
						want_q  <= free_address - heap_start_q - AW'(HEADER_BYTES);
						scan_q  <= '0;
						v_s1    <= 1'b0;
						found_q <= 1'b0;
						state_q <= (kind == bfha_pkg::KIND_ALLOC) ? S_ROUND : S_SCAN;
					end
				end
				S_ROUND: begin
					if (round_done) begin
						need_q  <= round_need;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					idx_s1 <= scan_q[IDX_W-1:0];
					if (scan_issue) begin
						scan_q <= scan_q + 1'b1;
					end
					v_s1 <= scan_issue;
					if (v_s1 && kind_q == bfha_pkg::KIND_FREE && rd_match) begin
						// First segment with this offset: remember its neighbours.
						best_q  <= idx_s1;
						match_q <= ent_rd;
						pf_q    <= (idx_s1 != '0) && !prev_q[ENT_W-1];
						state_q <= S_FNXT_RD;
					end else begin
						if (v_s1) begin
							prev_q <= ent_rd;
							if (kind_q == bfha_pkg::KIND_ALLOC && rd_better) begin
								found_q     <= 1'b1;
								best_q      <= idx_s1;
								best_diff_q <= rd_diff;
								best_off_q  <= rd_off;
								best_len_q  <= rd_len;
							end
						end else if (!scan_issue) begin
							if (kind_q == bfha_pkg::KIND_ALLOC) begin
								state_q <= S_ADEC;
							end else begin
								done    <= 1'b1;
								status  <= bfha_pkg::ST_UNKNOWN;
								address <= '0;
								state_q <= S_IDLE;
							end
						end
					end
				end
				S_ADEC: begin
					split_q <= do_split;
					if (!found_q) begin
						done    <= 1'b1;
						status  <= bfha_pkg::ST_NOFIT;
						address <= '0;
						state_q <= S_IDLE;
					end else if (do_split) begin
						// Open a gap after the chosen segment.
						sh_up_q  <= 1'b0;
						sh_src_q <= count_q - 1'b1;
						sh_cnt_q <= count_q - 1'b1 - CNT_W'(best_q);
						state_q  <= S_SH_RD;
					end else begin
						state_q <= S_A_BEST;
					end
				end
				S_SH_RD: begin
					if (sh_cnt_q == '0) begin
						state_q <= sh_up_q ? S_FFIN : S_A_SPLIT;
					end else begin
						state_q <= S_SH_WR;
					end
				end
				S_SH_WR: begin
					sh_cnt_q <= sh_cnt_q - 1'b1;
					sh_src_q <= sh_up_q ? sh_src_q + 1'b1 : sh_src_q - 1'b1;
					state_q  <= S_SH_RD;
				end
				S_A_SPLIT: begin
					count_q <= count_q + 1'b1;
					state_q <= S_A_BEST;
				end
				S_A_BEST: begin
					done    <= 1'b1;
					status  <= bfha_pkg::ST_ALLOC;
					address <= heap_start_q + AW'(best_off_q) + AW'(HEADER_BYTES);
					state_q <= S_IDLE;
				end
				S_FNXT_RD: begin
					if (best_nxt < count_q) begin
						state_q <= S_FNXT_WT;
					end else begin
						nf_q    <= 1'b0;
						state_q <= S_FMERGE;
					end
				end
				S_FNXT_WT: begin
					next_q  <= ent_rd;
					nf_q    <= !ent_rd[ENT_W-1];
					state_q <= S_FMERGE;
				end
				S_FMERGE: begin
					// Free segments never touch, so at most one neighbour merges on each side.
					gone_q   <= 2'(pf_q) + 2'(nf_q);
					sh_up_q  <= 1'b1;
					sh_src_q <= hi_idx + 1'b1;
					sh_cnt_q <= (pf_q || nf_q) ? count_q - 1'b1 - hi_idx : '0;
					state_q  <= S_SH_RD;
				end
				S_FFIN: begin
					count_q <= count_q - CNT_W'(gone_q);
					done    <= 1'b1;
					status  <= bfha_pkg::ST_FREED;
					address <= '0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "best_fit_heap_allocator_assert.svh"

	`BFHA_ASSERT_SAME(a_count_range, 1'b1, (count_q >= CNT_W'(1)) && (count_q <= CNT_W'(MAX_SEGMENTS)))
	`BFHA_ASSERT_NEXT(a_accept_busy, accept, busy)
	`BFHA_ASSERT_SAME(a_addr_zero, done && (status != bfha_pkg::ST_ALLOC), address == '0)
	`BFHA_ASSERT_NEXT(a_split_grows, state_q == S_A_SPLIT, count_q == $past(count_q) + 1'b1)

endmodule
`default_nettype wire
